### hw/rtl/lcp_pkg.sv
// shared types, codes and constants of the lcd controller port
package lcp_pkg;

	localparam int ROWS_DEF       = 64;
	localparam int ROW_BITS_DEF   = 120;
	localparam logic [7:0] BUSY_DELAY_RST = 8'd25;
	localparam logic [5:0] CONTRAST_RST   = 6'd18;
	localparam logic [5:0] CONTRAST_MAX   = 6'h3f;
	localparam logic [4:0] WORDS_8BIT     = 5'd15;
	localparam logic [4:0] WORDS_6BIT     = 5'd20;

	// item codes
	typedef enum logic [2:0] {
		CMD_COMMAND = 3'd0,
		CMD_DATA    = 3'd1,
		CMD_STATUS  = 3'd2,
		CMD_READ    = 3'd3,
		CMD_TICK    = 3'd4
	} cmd_t;

	// command byte prefixes
	localparam logic [6:0] OP_WORD_LEN = 7'b0000000;
	localparam logic [6:0] OP_ON_OFF   = 7'b0000001;
	localparam logic [5:0] OP_COUNTER  = 6'b000001;
	localparam logic [4:0] OP_OPAMP1   = 5'b00010;
	localparam logic [4:0] OP_OPAMP2   = 5'b00001;
	localparam logic [4:0] OP_TEST     = 5'b00011;
	localparam logic [2:0] OP_COL_ADDR = 3'b001;
	localparam logic [1:0] OP_SCROLL   = 2'b01;
	localparam logic [1:0] OP_ROW_ADDR = 2'b10;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       write_ignored;
		logic       display_on;
		logic [5:0] contrast;
		logic [5:0] scroll_offset;
		logic       test_mode;
	} out_item_t;

endpackage

### hw/rtl/lcp_row_store.sv
// pixel row memory with per-row valid bits and a registered read port
module lcp_row_store #(
	parameter int ROWS     = lcp_pkg::ROWS_DEF,
	parameter int ROW_BITS = lcp_pkg::ROW_BITS_DEF,
	localparam int AW      = $clog2(ROWS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [AW-1:0]       rd_addr,
	output logic [ROW_BITS-1:0] rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [ROW_BITS-1:0] wr_data
);
	import lcp_pkg::*;

	logic [ROW_BITS-1:0] mem [ROWS];
	logic [ROWS-1:0]     vld_q;
	logic [ROW_BITS-1:0] mem_rd_s1;
	logic                vld_rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		mem_rd_s1 <= mem[rd_addr];
	end

	// rows never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_rd_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			vld_rd_s1 <= vld_q[rd_addr];
		end
	end

	assign rd_data = vld_rd_s1 ? mem_rd_s1 : '0;

endmodule

### hw/rtl/lcp_top_placeholder_unused.sv
// column counter arithmetic of the lcd controller port
module lcp_col_step (
	input  logic       eight_bit,
	input  logic       count_up,
	input  logic [4:0] col,
	output logic [4:0] col_next
);
	import lcp_pkg::*;

	logic [4:0] words;
	logic [6:0] t;
	logic [6:0] w1;
	logic [6:0] w2;
	logic [6:0] w3;

	// wraps modulo the word count, also from a pointer set past it
	always_comb begin
		words = eight_bit ? WORDS_8BIT : WORDS_6BIT;
		w1 = {2'b00, words};
		w2 = {1'b0, words, 1'b0};
		w3 = w1 + w2;
		if (count_up) begin
			t = {2'b00, col} + 7'd1;
		end else begin
			t = {2'b00, col} + w1 - 7'd1;
		end
		if (t >= w3) begin
			col_next = 5'(t - w3);
		end else if (t >= w2) begin
			col_next = 5'(t - w2);
		end else if (t >= w1) begin
			col_next = 5'(t - w1);
		end else begin
			col_next = t[4:0];
		end
	end

endmodule

### hw/rtl/lcd_controller_port_top.sv
// Command/data port of a monochrome graphic lcd controller with a row pixel store.
//
// in channel: in_valid/in_stall carry one item (cmd, value): command write,
// data write, status read, data read or tick. out channel: out_valid/out_stall
// return exactly one item per input item, holding the read word or status,
// the write-dropped flag and the current display settings.
// cfg channel: cfg_valid/cfg_ready writes busy_delay; cfg_ready is always high.
// Every item runs through ST_IDLE and ST_EXEC: the accepting edge reads the addressed pixel
// row from the row memory into a register; for a data write, ST_EXEC merges the word and
// writes the row back once the output register can take the result. No new item is
// accepted in ST_EXEC; the result is registered at the edge that ends ST_EXEC.
// The result sits in an output register, so the next item is taken while a
// stalled result waits; an item in flight holds until that register frees.
// Reset sets all settings to their reset values and clears the per-row valid bits,
// so the whole pixel store reads as zero right after reset with no clearing pass.
// After an accepted write, writes are dropped until busy_delay ticks pass.
module lcd_controller_port_top #(
	parameter int ROWS     = lcp_pkg::ROWS_DEF,
	parameter int ROW_BITS = lcp_pkg::ROW_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lcp_pkg::in_item_t in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output lcp_pkg::out_item_t out_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);
	import lcp_pkg::*;

	localparam int AW = $clog2(ROWS);

	state_t state_q, state_n;
	in_item_t item_s1;
	out_item_t out_item_q, out_item_n;
	logic out_valid_q;

	logic [7:0] busy_delay_q;
	logic [5:0] row_q, row_n;
	logic [4:0] col_q, col_n;
	logic [5:0] scroll_q, scroll_n;
	logic       disp_q, disp_n;
	logic       test_q, test_n;
	logic       eight_q, eight_n;
	logic       up_q, up_n;
	logic       colsel_q, colsel_n;
	logic [1:0] opa1_q, opa1_n;
	logic [1:0] opa2_q, opa2_n;
	logic [5:0] contrast_q, contrast_n;
	logic       dummy_q, dummy_n;
	logic [7:0] busy_q, busy_n;

	logic                accept;
	logic                done;
	logic                row_ok;
	logic [ROW_BITS-1:0] rd_row;
	logic [ROW_BITS-1:0] rd_row_ok;
	logic [ROW_BITS-1:0] wr_row;
	logic                wr_en;
	logic [4:0]          col_step;
	logic [7:0]          base;
	logic [7:0]          word_rev;
	logic [7:0]          word_mask;
	logic [ROW_BITS-1:0] mask_sh;
	logic [ROW_BITS-1:0] data_sh;
	logic [ROW_BITS-1:0] rd_sh;
	logic [7:0]          rd_word;
	logic [7:0]          c;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign row_ok = ({1'b0, row_q} < 7'(ROWS));

	lcp_row_store #(
		.ROWS     (ROWS),
		.ROW_BITS (ROW_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (row_q[AW-1:0]),
		.rd_data (rd_row),
		.wr_en   (wr_en),
		.wr_addr (row_q[AW-1:0]),
		.wr_data (wr_row)
	);

	lcp_col_step u_col_step (
		.eight_bit (eight_q),
		.count_up  (up_q),
		.col       (col_q),
		.col_next  (col_step)
	);

	// word placement: most significant data bit lands on the lowest pixel
	always_comb begin
		if (eight_q) begin
			base = {col_q, 3'b000};
		end else begin
			base = {1'b0, col_q, 2'b00} + {2'b00, col_q, 1'b0};
		end
		c = item_s1.value;
		word_rev = '0;
		if (eight_q) begin
			word_mask = 8'hff;
			for (int i = 0; i < 8; i++) begin
				word_rev[i] = c[7-i];
			end
		end else begin
			word_mask = 8'h3f;
			for (int i = 0; i < 6; i++) begin
				word_rev[i] = c[5-i];
			end
		end
		rd_row_ok = row_ok ? rd_row : '0;
		mask_sh = {{(ROW_BITS-8){1'b0}}, word_mask} << base;
		data_sh = {{(ROW_BITS-8){1'b0}}, word_rev} << base;
		wr_row  = (rd_row_ok & ~mask_sh) | (data_sh & mask_sh);
		rd_sh   = rd_row_ok >> base;
		rd_word = '0;
		if (eight_q) begin
			for (int i = 0; i < 8; i++) begin
				rd_word[7-i] = rd_sh[i];
			end
		end else begin
			for (int i = 0; i < 6; i++) begin
				rd_word[5-i] = rd_sh[i];
			end
		end
	end

	always_comb begin
		state_n    = state_q;
		done       = 1'b0;
		wr_en      = 1'b0;
		row_n      = row_q;
		col_n      = col_q;
		scroll_n   = scroll_q;
		disp_n     = disp_q;
		test_n     = test_q;
		eight_n    = eight_q;
		up_n       = up_q;
		colsel_n   = colsel_q;
		opa1_n     = opa1_q;
		opa2_n     = opa2_q;
		contrast_n = contrast_q;
		dummy_n    = dummy_q;
		busy_n     = busy_q;
		out_item_n = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// finish only when the output register can take the result
				if (!out_valid_q || !out_stall) begin
					done    = 1'b1;
					state_n = ST_IDLE;
					case (item_s1.cmd)
						CMD_COMMAND: begin
							if (busy_q != 8'd0) begin
								out_item_n.write_ignored = 1'b1;
							end else begin
								busy_n = busy_delay_q;
								if (c[7:1] == OP_WORD_LEN) begin
									eight_n = c[0];
								end else if (c[7:1] == OP_ON_OFF) begin
									disp_n = c[0];
								end else if (c[7:2] == OP_COUNTER) begin
									up_n     = c[0];
									colsel_n = c[1];
								end else if (c[7:3] == OP_OPAMP1) begin
									opa1_n = c[1:0];
								end else if (c[7:3] == OP_OPAMP2) begin
									opa2_n = c[1:0];
								end else if (c[7:3] == OP_TEST) begin
									test_n     = c[2];
									contrast_n = CONTRAST_MAX;
								end else if (c[7:5] == OP_COL_ADDR) begin
									col_n   = c[4:0];
									dummy_n = 1'b1;
								end else if (c[7:6] == OP_SCROLL) begin
									scroll_n = c[5:0];
								end else if (c[7:6] == OP_ROW_ADDR) begin
									row_n   = c[5:0];
									dummy_n = 1'b1;
								end else begin
									contrast_n = c[5:0];
								end
							end
						end
						CMD_DATA: begin
							if (busy_q != 8'd0) begin
								out_item_n.write_ignored = 1'b1;
							end else begin
								busy_n = busy_delay_q;
								wr_en  = row_ok;
								if (colsel_q) begin
									col_n = col_step;
								end else begin
									row_n = up_q ? row_q + 6'd1 : row_q - 6'd1;
								end
							end
						end
						CMD_STATUS: begin
							out_item_n.read_value = {(busy_q != 8'd0), eight_q, disp_q,
								3'b000, colsel_q, up_q};
						end
						CMD_READ: begin
							if (dummy_q) begin
								dummy_n = 1'b0;
							end else begin
								out_item_n.read_value = rd_word;
								if (colsel_q) begin
									col_n = col_step;
								end else begin
									row_n = up_q ? row_q + 6'd1 : row_q - 6'd1;
								end
							end
						end
						CMD_TICK: begin
							if (busy_q != 8'd0) begin
								busy_n = busy_q - 8'd1;
							end
						end
						default: begin
						end
					endcase
					out_item_n.display_on    = disp_n;
					out_item_n.contrast      = contrast_n;
					out_item_n.scroll_offset = scroll_n;
					out_item_n.test_mode     = test_n;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			busy_delay_q <= BUSY_DELAY_RST;
			row_q        <= '0;
			col_q        <= '0;
			scroll_q     <= '0;
			disp_q       <= 1'b0;
			test_q       <= 1'b0;
			eight_q      <= 1'b1;
			up_q         <= 1'b1;
			colsel_q     <= 1'b1;
			opa1_q       <= '0;
			opa2_q       <= '0;
			contrast_q   <= CONTRAST_RST;
			dummy_q      <= 1'b1;
			busy_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				busy_delay_q <= cfg_data;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (done) begin
				row_q      <= row_n;
				col_q      <= col_n;
				scroll_q   <= scroll_n;
				disp_q     <= disp_n;
				test_q     <= test_n;
				eight_q    <= eight_n;
				up_q       <= up_n;
				colsel_q   <= colsel_n;
				opa1_q     <= opa1_n;
				opa2_q     <= opa2_n;
				contrast_q <= contrast_n;
				dummy_q    <= dummy_n;
				busy_q     <= busy_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
		if (done) begin
			out_item_q <= out_item_n;
		end
	end

endmodule
